// File: hdl/range_add_leftmost_zero_tree_core_defines.svh
// Assertion macros for the range-add leftmost-zero core.
`ifndef RANGE_ADD_LEFTMOST_ZERO_TREE_CORE_DEFINES_SVH
`define RANGE_ADD_LEFTMOST_ZERO_TREE_CORE_DEFINES_SVH

// Implication checked at every rising edge, masked while reset is low.
`define RALZ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define RALZ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ralz_pkg.sv
// Package: payload types and constants of the range-add leftmost-zero core.
`default_nettype none
package ralz_pkg;
    localparam int unsigned SIZE_DEF  = 1024;
    localparam int unsigned IDX_W     = 10;
    localparam int unsigned DELTA_W   = 8;
    localparam int unsigned CNT_W     = 16;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [IDX_W-1:0]          lo;
        logic [IDX_W-1:0]          hi;
        logic signed [DELTA_W-1:0] delta;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
    } t_out_item;
endpackage
`default_nettype wire

// File: hdl/range_add_leftmost_zero_tree_core.sv
// Top level: counter array in one memory, range add and leftmost-zero search.
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+-------------------------------
//  input   | i_in_valid | o_in_stall  | i_in_data  (op, lo, hi, delta)
//  output  | o_out_valid| i_out_stall | o_out_data (found, position)
//
// Walk: an item walks lo..hi (hi clipped to SIZE-1) through the counter
// memory one entry per cycle, set by its single read and write port; the
// input stalls until the item's result is loaded. A find stops at the first
// zero. An empty range goes from S_IDLE straight to S_FINISH.
// Reset: a clearing pass writes zero to all SIZE entries, with the input
// stalled. The output register holds a result while i_out_stall is high;
// the next item is taken meanwhile.
`default_nettype none
`include "range_add_leftmost_zero_tree_core_defines.svh"
module range_add_leftmost_zero_tree_core #(
    parameter int unsigned SIZE = ralz_pkg::SIZE_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  ralz_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output ralz_pkg::t_out_item o_out_data
);
    import ralz_pkg::*;

    // address width of the counter memory; CW compares indexes of both sizes
    localparam int unsigned AW = (SIZE > 2) ? $clog2(SIZE) : 1;
    localparam int unsigned CW = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam logic [CW-1:0] LAST = CW'(SIZE - 1);
    localparam logic signed [CNT_W:0] SAT_HI = (CNT_W+1)'(2**(CNT_W-1) - 1);
    localparam logic signed [CNT_W:0] SAT_LO = -(CNT_W+1)'(2**(CNT_W-1));

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RUN, S_FINISH} t_state;

    t_state                  r_state;
    logic [AW-1:0]           r_clr;
    logic [AW-1:0]           r_addr;     // next entry to read
    logic [AW-1:0]           r_end;      // last entry of the range
    logic                    r_issuing;  // reads still to issue
    logic                    r_p_valid;  // read data for r_p_addr arrives now
    logic [AW-1:0]           r_p_addr;
    logic                    r_op;
    logic signed [DELTA_W-1:0] r_delta;
    logic                    r_found;
    logic [IDX_W-1:0]        r_pos;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    logic signed [CNT_W-1:0] r_mem [SIZE];
    logic signed [CNT_W-1:0] r_rdata;

    logic [CW-1:0]           n_lo;
    logic [CW-1:0]           n_hi;
    logic signed [CNT_W:0]   n_sum;
    logic signed [CNT_W-1:0] n_wdata;
    logic [AW-1:0]           n_waddr;
    logic                    n_wen;
    logic                    n_hit;
    logic                    n_load;
    logic [CW-1:0]           n_pos_ext;

    // range after clipping hi to the array
    always_comb begin
        n_lo = CW'(i_in_data.lo);
        n_hi = CW'(i_in_data.hi);
        if (n_hi > LAST) begin
            n_hi = LAST;
        end
    end

    // saturating add of the delta to the counter just read
    always_comb begin
        n_sum = (CNT_W+1)'(r_rdata) + (CNT_W+1)'(r_delta);
        if (n_sum > SAT_HI) begin
            n_wdata = SAT_HI[CNT_W-1:0];
        end else if (n_sum < SAT_LO) begin
            n_wdata = SAT_LO[CNT_W-1:0];
        end else begin
            n_wdata = n_sum[CNT_W-1:0];
        end
    end

    assign n_hit     = (r_state == S_RUN) && r_p_valid && (r_op == OP_FIND) && (r_rdata == '0);
    assign n_pos_ext = CW'(r_p_addr);
    assign n_load    = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    // write port: clearing pass or add write-back
    always_comb begin
        n_wen   = 1'b0;
        n_waddr = r_p_addr;
        if (r_state == S_CLEAR) begin
            n_wen   = 1'b1;
            n_waddr = r_clr;
        end else if (r_state == S_RUN && r_p_valid && r_op == OP_ADD) begin
            n_wen = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wen) begin
            r_mem[n_waddr] <= (r_state == S_CLEAR) ? '0 : n_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_issuing   <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (CW'(r_clr) == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_data.op;
                        r_delta <= i_in_data.delta;
                        r_found <= 1'b0;
                        r_pos   <= '0;
                        r_addr  <= n_lo[AW-1:0];
                        r_end   <= n_hi[AW-1:0];
                        if (n_lo > n_hi) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_issuing <= 1'b1;
                            r_state   <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    // one read issued per cycle; data checked from the registered read
                    r_p_valid <= r_issuing;
                    r_p_addr  <= r_addr;
                    if (r_issuing) begin
                        if (r_addr == r_end) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    if (n_hit) begin
                        r_found   <= 1'b1;
                        r_pos     <= n_pos_ext[IDX_W-1:0];
                        r_issuing <= 1'b0;
                        r_p_valid <= 1'b0;
                        r_state   <= S_FINISH;
                    end else if (!r_issuing && !r_p_valid) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (n_load) begin
                        r_out_valid         <= 1'b1;
                        r_out_data.found    <= r_found;
                        r_out_data.position <= r_pos;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `RALZ_ASSERT(a_pipe_only_in_run, i_clk, i_rst_n, r_p_valid |-> (r_state == S_RUN), "read pipe active outside a walk")
    `RALZ_ASSERT(a_no_result_in_clear, i_clk, i_rst_n, (r_state == S_CLEAR) |-> !r_out_valid, "result during clearing pass")
    `RALZ_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_state == S_CLEAR) && !r_out_valid, "reset did not start clearing")
endmodule
`default_nettype wire

// File: verif/range_add_leftmost_zero_tree_core_tb.sv
// Testbench for the range-add leftmost-zero core: randomized range adds and zero searches.
`timescale 1ns / 100ps
`default_nettype none
module range_add_leftmost_zero_tree_core_tb;
    import ralz_pkg::*;

    localparam int unsigned NCNT = SIZE_DEF;
    localparam int CNT_LO = -32768;
    localparam int CNT_HI = 32767;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    range_add_leftmost_zero_tree_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Flat copy of the counters.
    int        counters [NCNT];
    t_out_item expected_results [$];
    int        n_mismatch;
    int        n_sent;
    int        n_checked;
    int        n_found;
    int        send_idle_pct;
    int        recv_stall_pct;

    // Apply one item to the counter copy and return the result it gives.
    function automatic t_out_item predict_counters(t_in_item it);
        t_out_item r;
        int        lo_i;
        int        hi_i;
        int        s;
        r = '0;
        lo_i = it.lo;
        hi_i = (it.hi > NCNT - 1) ? NCNT - 1 : it.hi;
        if (lo_i <= hi_i) begin
            if (it.op == OP_ADD) begin
                for (int k = lo_i; k <= hi_i; k++) begin
                    s = counters[k] + int'(it.delta);
                    if (s < CNT_LO) s = CNT_LO;
                    if (s > CNT_HI) s = CNT_HI;
                    counters[k] = s;
                end
            end else begin
                for (int k = lo_i; k <= hi_i; k++) begin
                    if (counters[k] == 0) begin
                        r.found = 1'b1;
                        r.position = k[IDX_W-1:0];
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    // Send one item: hold valid until the transfer, random gap before it.
    // Valid stays high past the transfer; the next call replaces or drops it; a drain drops it.
    task automatic send_item(input logic op, input int lo, input int hi, input int delta);
        t_in_item it;
        it.op = op;
        it.lo = lo[IDX_W-1:0];
        it.hi = hi[IDX_W-1:0];
        it.delta = delta[DELTA_W-1:0];
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // Input no longer stalled; predict in acceptance order.
        expected_results.push_back(predict_counters(it));
        n_sent++;
    endtask

    // Wait until every expected result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver stall, randomized per cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checker: compares each transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: unexpected result found=%0d position=%0d",
                             o_out_data.found, o_out_data.position);
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                if (want.found) n_found++;
                if (o_out_data.found !== want.found || o_out_data.position !== want.position)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR: result %0d expected found=%0d pos=%0d, got %0d/%0d",
                                 n_checked, want.found, want.position,
                                 o_out_data.found, o_out_data.position);
                end
            end
        end
    end

    // Random index, biased to small ranges so runs stay short.
    function automatic int pick_hi(int lo);
        int span;
        span = $urandom_range(40);
        case ($urandom_range(9))
            0:       return $urandom_range(1023);
            1:       return (lo == 0) ? 0 : lo - 1;
            default: return (lo + span > 1023) ? 1023 : lo + span;
        endcase
    endfunction

    // Directed: field extremes, both operations, reversed range.
    task automatic test_directed();
        send_item(OP_FIND, 0, 1023, 0);
        send_item(OP_ADD, 0, 1023, 127);
        send_item(OP_FIND, 0, 1023, -1);
        send_item(OP_ADD, 0, 0, -127);
        send_item(OP_FIND, 0, 1023, 0);
        send_item(OP_ADD, 5, 3, -128);     // reversed, no effect
        send_item(OP_FIND, 9, 2, 0);       // reversed, not found
        send_item(OP_ADD, 1023, 1023, -127);
        send_item(OP_FIND, 1, 1023, 0);
        for (int k = 0; k < 6; k++) send_item(OP_ADD, 10, 12, 127);
        for (int k = 0; k < 5; k++) send_item(OP_ADD, 11, 11, 127);
        send_item(OP_ADD, 10, 12, -128);
        send_item(OP_ADD, 20, 20, -128);
        send_item(OP_FIND, 0, 1023, 85);
        send_item(OP_ADD, 0, 1023, -127);
        send_item(OP_FIND, 0, 1023, -86);
        drain_results();
    endtask

    // Random phase: mixed adds, zero-producing adds and finds.
    task automatic test_random(int n, int idle, int stall);
        int lo;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < n; k++) begin
            lo = $urandom_range(1023);
            if ($urandom_range(2) == 0)
                send_item(OP_FIND, lo, pick_hi(lo), $urandom_range(255) - 128);
            else if ($urandom_range(3) == 0)
                // Small deltas so counters come back to zero often.
                send_item(OP_ADD, lo, pick_hi(lo), $urandom_range(2) - 1);
            else
                send_item(OP_ADD, lo, pick_hi(lo), $urandom_range(255) - 128);
        end
    endtask

    // Pressure: the sender holds off until the block has returned everything.
    task automatic test_drain_pause();
        drain_results();
        repeat (20) @(posedge i_clk);
        send_item(OP_FIND, 0, 1023, 0);
        drain_results();
    endtask

    initial begin
        n_mismatch = 0;
        n_sent = 0;
        n_checked = 0;
        n_found = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (counters[k]) counters[k] = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(290, 0, 0);
        test_random(280, 51, 0);
        test_drain_pause();
        test_random(280, 0, 51);
        test_random(280, 34, 34);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain_results();
        repeat (50) @(posedge i_clk);

        $display("Sent %0d items, checked %0d results, %0d finds located a zero.",
                 n_sent, n_checked, n_found);
        if (n_mismatch == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mismatch,
                     expected_results.size());
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: covers about 1200 items with stalls, plus clearing.
    initial begin
        #40ms;
        $display("Timeout");
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
+incdir+hdl
hdl/ralz_pkg.sv
hdl/range_add_leftmost_zero_tree_core.sv
verif/range_add_leftmost_zero_tree_core_tb.sv
